### rtl/core/mwc_pkg.sv
// Shared types and constants of the multiply-with-carry generator.
`timescale 1ns / 1ps

package mwc_pkg;

   typedef logic [2:0]  op_type;
   typedef logic [31:0] word_type;

   localparam op_type OP_RAW     = 3'd0;
   localparam op_type OP_RANGE   = 3'd1;
   localparam op_type OP_MOD     = 3'd2;
   localparam op_type OP_RESEED  = 3'd3;
   localparam op_type OP_SAVE    = 3'd4;
   localparam op_type OP_RESTORE = 3'd5;

   localparam logic [15:0] MUL_Z     = 16'd36969;
   localparam logic [15:0] MUL_W     = 16'd18000;
   localparam word_type    RESET_W   = 32'd521288629;
   localparam word_type    RESET_Z   = 32'd362436069;

   localparam int DIV_STEPS = 32;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   typedef struct packed {
      logic capture;
      logic exec;
      logic div_step;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic needs_div;
      logic out_free;
   } dp_status_type;

endpackage

### rtl/core/mwc_ctrl.sv
// Sequencer of the multiply-with-carry generator: accept, execute, divide, finish.
`timescale 1ns / 1ps

module mwc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mwc_pkg::dp_status_type status,
   output mwc_pkg::ctrl_cmd_type  cmd
);
   import mwc_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             count_last;

   assign count_last = (count_ff == CNT_W'(DIV_STEPS - 1));
   assign req_ready  = (state_ff == ST_IDLE) && !reset;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            count_in = '0;
            state_in = status.needs_div ? ST_DIV : ST_FIN;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff + 1'b1;
            if (count_last) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

### rtl/core/mwc_dp.sv
// Datapath: generator lanes, save store, restoring divider and result register.
`timescale 1ns / 1ps

module mwc_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  mwc_pkg::op_type        req_op,
   input  mwc_pkg::word_type      req_range_low,
   input  mwc_pkg::word_type      req_range_high,
   input  mwc_pkg::word_type      req_modulus,
   input  mwc_pkg::word_type      req_seed_u,
   input  mwc_pkg::word_type      req_seed_v,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output mwc_pkg::word_type      rsp_value,
   output logic                   rsp_zero_divisor,
   input  mwc_pkg::ctrl_cmd_type  cmd,
   output mwc_pkg::dp_status_type status
);
   import mwc_pkg::*;

   word_type lane_w_ff, lane_z_ff, saved_w_ff, saved_z_ff;
   op_type   op_ff;
   word_type low_ff, div_ff, seed_u_ff, seed_v_ff;
   word_type quo_ff, rem_ff;
   word_type value_ff, value_in;
   logic     flag_ff, flag_in, valid_ff;

   word_type    z_next, w_next, draw;
   logic [32:0] trial, trial_sub;
   logic        is_reduce, div_zero;

   // One multiply-with-carry step on each lane.
   assign z_next = ({16'b0, MUL_Z} * {16'b0, lane_z_ff[15:0]}) + {16'b0, lane_z_ff[31:16]};
   assign w_next = ({16'b0, MUL_W} * {16'b0, lane_w_ff[15:0]}) + {16'b0, lane_w_ff[31:16]};
   assign draw   = {z_next[15:0], 16'b0} + w_next;

   assign is_reduce = (op_ff == OP_RANGE) || (op_ff == OP_MOD);
   assign div_zero  = (div_ff == '0);

   assign status.needs_div = is_reduce && !div_zero;
   assign status.out_free  = !valid_ff || rsp_ready;

   // Restoring division step: shift in the next dividend bit, subtract if it fits.
   assign trial     = {rem_ff, quo_ff[31]};
   assign trial_sub = trial - {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_op;
         low_ff    <= req_range_low;
         div_ff    <= (req_op == OP_RANGE) ? (req_range_high - req_range_low + 32'd1)
                                           : req_modulus;
         seed_u_ff <= req_seed_u;
         seed_v_ff <= req_seed_v;
      end
      if (cmd.exec) begin
         quo_ff <= draw;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[30:0], 1'b0};
         rem_ff <= trial_sub[32] ? trial[31:0] : trial_sub[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_w_ff  <= RESET_W;
         lane_z_ff  <= RESET_Z;
         saved_w_ff <= '0;
         saved_z_ff <= '0;
      end else if (cmd.exec) begin
         unique case (op_ff)
            OP_RAW, OP_RANGE, OP_MOD: begin
               lane_w_ff <= w_next;
               lane_z_ff <= z_next;
            end
            OP_RESEED: begin
               if (seed_u_ff != '0) lane_w_ff <= seed_u_ff;
               if (seed_v_ff != '0) lane_z_ff <= seed_v_ff;
            end
            OP_SAVE: begin
               saved_w_ff <= lane_w_ff;
               saved_z_ff <= lane_z_ff;
            end
            OP_RESTORE: begin
               lane_w_ff <= saved_w_ff;
               lane_z_ff <= saved_z_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      flag_in = is_reduce && div_zero;
      unique case (op_ff)
         OP_RAW:   value_in = quo_ff;
         OP_RANGE: value_in = low_ff + (div_zero ? quo_ff : rem_ff);
         OP_MOD:   value_in = div_zero ? quo_ff : rem_ff;
         default:  value_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         value_ff <= value_in;
         flag_ff  <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_value        = value_ff;
   assign rsp_zero_divisor = flag_ff;

endmodule

### rtl/core/multiply_with_carry_rng.sv
// Top level of the two-lane multiply-with-carry random generator.
// From an accepted beat to its result: capture, execute and finish for raw, reseed,
// save, restore and zero-divisor draws; range and modulo draws run the 32-step divider
// before finish, which waits for a free result register; only then is a new beat taken.
// Reset (synchronous): lanes to their seeds, save store to zero, result register empty.
`timescale 1ns / 1ps

module multiply_with_carry_rng (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mwc_pkg::op_type   req_op,
   input  mwc_pkg::word_type req_range_low,
   input  mwc_pkg::word_type req_range_high,
   input  mwc_pkg::word_type req_modulus,
   input  mwc_pkg::word_type req_seed_u,
   input  mwc_pkg::word_type req_seed_v,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mwc_pkg::word_type rsp_value,
   output logic              rsp_zero_divisor
);
   import mwc_pkg::*;

   // Commands flow from the sequencer, status flows back; nothing else links them.
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Sequencer: takes a beat only when idle, then steps execute, divide (only for
   // reductions with a nonzero divisor) and finish. Finish holds until the result
   // register is free, so a waiting result blocks the next beat from being accepted.
   mwc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: lanes advance once per draw; the divider reduces the draw one
   // quotient bit per cycle; the result register parts the two channels.
   mwc_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_op           (req_op),
      .req_range_low    (req_range_low),
      .req_range_high   (req_range_high),
      .req_modulus      (req_modulus),
      .req_seed_u       (req_seed_u),
      .req_seed_v       (req_seed_v),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_value        (rsp_value),
      .rsp_zero_divisor (rsp_zero_divisor),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

### rtl/core/mwc_checker.sv
// Port-level checks of the multiply-with-carry generator and their binding.
`timescale 1ns / 1ps

module mwc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input mwc_pkg::op_type   req_op,
   input mwc_pkg::word_type req_modulus,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mwc_pkg::word_type rsp_value,
   input logic              rsp_zero_divisor
);
   import mwc_pkg::*;

   logic req_beat;
   assign req_beat = req_valid && req_ready;

   // A stalled result beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_zero_divisor))
      else $error("result beat changed while stalled");

   // One beat at a time: ready drops right after a beat is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_ready)
      else $error("second beat accepted while busy");

   // Non-draw ops return zero without the flag.
   assert property (@(posedge clock) disable iff (reset)
      req_beat && !rsp_valid &&
      (req_op == OP_RESEED || req_op == OP_SAVE || req_op == OP_RESTORE)
      |-> ##3 (rsp_valid && rsp_value == '0 && !rsp_zero_divisor))
      else $error("non-draw op gave a wrong result");

   // A zero modulus skips the divider and raises the flag.
   assert property (@(posedge clock) disable iff (reset)
      req_beat && !rsp_valid && req_op == OP_MOD && req_modulus == '0
      |-> ##3 (rsp_valid && rsp_zero_divisor))
      else $error("zero modulus not flagged");

   // Reset empties the result register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind multiply_with_carry_rng mwc_checker u_mwc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_op           (req_op),
   .req_modulus      (req_modulus),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_value        (rsp_value),
   .rsp_zero_divisor (rsp_zero_divisor)
);
